[rtl/bdrb_pkg.sv]
`default_nettype none

package bdrb_pkg;

  // storage geometry
  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // operation codes carried by one input beat
  typedef enum logic [1:0] {
    CMD_PUSH_TAIL = 2'd0,
    CMD_PUSH_HEAD = 2'd1,
    CMD_POP_HEAD  = 2'd2,
    CMD_POP_TAIL  = 2'd3
  } cmd_e;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctrl_t;

  // slot after i, wrapping by compare against the capacity in use
  function automatic logic [AddrW-1:0] next_slot(input logic [AddrW-1:0] i,
                                                 input logic [CntW-1:0] cap);
    logic [CntW-1:0] inc;
    inc = CntW'(i) + CntW'(1);
    next_slot = (inc >= cap) ? '0 : inc[AddrW-1:0];
  endfunction

  // slot before i, wrapping to the last slot in use
  function automatic logic [AddrW-1:0] prev_slot(input logic [AddrW-1:0] i,
                                                 input logic [CntW-1:0] cap);
    logic [CntW-1:0] last;
    last = cap - CntW'(1);
    if ((i == '0) || (CntW'(i) >= cap)) begin
      prev_slot = last[AddrW-1:0];
    end else begin
      prev_slot = i - AddrW'(1);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/bdrb_ctrl.sv]
`default_nettype none

module bdrb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output bdrb_pkg::ctrl_t     ctrl_o
);

  bdrb_pkg::state_e state_q, state_d;

  // next state: take a beat, execute, present the result
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bdrb_pkg::ST_IDLE: begin
        if (start) state_d = bdrb_pkg::ST_EXEC;
      end
      bdrb_pkg::ST_EXEC: state_d = bdrb_pkg::ST_RESP;
      bdrb_pkg::ST_RESP: state_d = bdrb_pkg::ST_IDLE;
      default:           state_d = bdrb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands to the datapath
  assign busy        = (state_q != bdrb_pkg::ST_IDLE);
  assign ctrl_o.load = (state_q == bdrb_pkg::ST_IDLE) && start;
  assign ctrl_o.exec = (state_q == bdrb_pkg::ST_EXEC);
  assign ctrl_o.resp = (state_q == bdrb_pkg::ST_RESP);

endmodule

`default_nettype wire

[rtl/bdrb_datapath.sv]
`default_nettype none

module bdrb_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bdrb_pkg::ctrl_t            ctrl_i,
  input  wire logic [1:0]                 cmd_i,
  input  wire logic [7:0]                 data_in_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [bdrb_pkg::CntW-1:0]  cfg_data_i,
  output logic                            accepted_o,
  output logic [7:0]                      data_out_o,
  output logic [bdrb_pkg::CntW-1:0]       level_o
);

  localparam int unsigned AW = bdrb_pkg::AddrW;
  localparam int unsigned CW = bdrb_pkg::CntW;

  logic [7:0]    mem_q [bdrb_pkg::Depth];
  logic [7:0]    rdata_q;

  bdrb_pkg::cmd_e cmd_q;
  logic [7:0]    din_q;
  logic [CW-1:0] cap_q, cap_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          ok_q, ok_d;
  logic          pop_q, pop_d;
  logic [AW-1:0] addr;
  logic          wr_en;
  logic          has_room;
  logic          has_data;

  // latch the incoming beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= bdrb_pkg::cmd_e'(cmd_i);
      din_q <= data_in_i;
    end
  end

  // capacity clamp on a register write
  always_comb begin
    priority if (cfg_data_i == '0) begin
      cap_d = CW'(1);
    end else if (cfg_data_i > CW'(bdrb_pkg::Depth)) begin
      cap_d = CW'(bdrb_pkg::Depth);
    end else begin
      cap_d = cfg_data_i;
    end
  end

  assign has_room = (fill_q < cap_q);
  assign has_data = (fill_q != '0);

  // pointer and level update for the operation in flight
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    ok_d   = 1'b0;
    pop_d  = 1'b0;
    addr   = tail_q;
    wr_en  = 1'b0;
    unique case (cmd_q)
      bdrb_pkg::CMD_PUSH_TAIL: begin
        addr = tail_q;
        if (has_room) begin
          wr_en  = 1'b1;
          tail_d = bdrb_pkg::next_slot(tail_q, cap_q);
          fill_d = fill_q + CW'(1);
          ok_d   = 1'b1;
        end
      end
      bdrb_pkg::CMD_PUSH_HEAD: begin
        addr = bdrb_pkg::prev_slot(head_q, cap_q);
        if (has_room) begin
          wr_en  = 1'b1;
          head_d = addr;
          fill_d = fill_q + CW'(1);
          ok_d   = 1'b1;
        end
      end
      bdrb_pkg::CMD_POP_HEAD: begin
        pop_d = 1'b1;
        addr  = head_q;
        if (has_data) begin
          head_d = bdrb_pkg::next_slot(head_q, cap_q);
          fill_d = fill_q - CW'(1);
          ok_d   = 1'b1;
        end
      end
      bdrb_pkg::CMD_POP_TAIL: begin
        pop_d = 1'b1;
        addr  = bdrb_pkg::prev_slot(tail_q, cap_q);
        if (has_data) begin
          tail_d = addr;
          fill_d = fill_q - CW'(1);
          ok_d   = 1'b1;
        end
      end
      default: begin
        addr = tail_q;
      end
    endcase
  end

  // byte store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wr_en) begin
      mem_q[addr] <= din_q;
    end
    if (ctrl_i.exec) begin
      rdata_q <= mem_q[addr];
    end
  end

  // ring state and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CW'(bdrb_pkg::Depth);
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cap_d;
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else if (ctrl_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // result flags held for the response cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      ok_q  <= ok_d;
      pop_q <= pop_d;
    end
  end

  assign accepted_o = ok_q;
  assign data_out_o = (ok_q && pop_q) ? rdata_q : 8'd0;
  assign level_o    = fill_q;

endmodule

`default_nettype wire

[rtl/byte_deque_ring_buffer_top.sv]
`default_nettype none

// Double-ended ring of bytes: push at tail, push before head, pop head, pop tail.
// Command channel: cmd_i and data_in_i are taken at a clock edge with start high
// and busy low. busy stays high until the result beat has been shown.
// Result channel: done_o is high for exactly one cycle with accepted_o,
// data_out_o and level_o valid; the receiver takes it then and cannot stall.
// A refused push (store full) or pop (store empty) gives accepted_o low,
// data_out_o zero and the level unchanged.
// Sequence: after the accepting edge the controller passes through execute
// (pointer update and one access to the single-port byte memory) and then
// respond (registered read data out), in which done_o is high. One beat is in
// flight at a time, so no new beat is taken until the result beat has been shown.
// Configuration: cfg_we_i writes cfg_data_i as the capacity in use (0 is taken
// as 1, values above the depth as the depth) and empties the store; write it
// only while busy is low.
// Reset empties the store and sets the capacity to the full depth; the byte
// memory itself is not cleared.
module byte_deque_ring_buffer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [7:0]                data_in_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [bdrb_pkg::CntW-1:0] cfg_data_i,
  output logic                           done_o,
  output logic                           accepted_o,
  output logic [7:0]                     data_out_o,
  output logic [bdrb_pkg::CntW-1:0]      level_o
);

  bdrb_pkg::ctrl_t ctrl;

  // sequencer
  bdrb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // ring pointers and byte store
  bdrb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cmd_i      (cmd_i),
    .data_in_i  (data_in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .accepted_o (accepted_o),
    .data_out_o (data_out_o),
    .level_o    (level_o)
  );

  assign done_o = ctrl.resp;

endmodule

`default_nettype wire

[rtl/bdrb_checker.sv]
`default_nettype none

module bdrb_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done_o,
  input wire logic                      accepted_o,
  input wire logic [7:0]                data_out_o,
  input wire logic [bdrb_pkg::CntW-1:0] level_o
);

  // an accepted beat is answered by a result beat
  a_resp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result beat not two cycles after accept");

  // block is back to idle right after the result beat
  a_idle_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result beat");

  // a refused operation carries no byte
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (data_out_o == 8'd0))
    else $error("refused beat with nonzero data");

  // at a result beat the level does not exceed the store depth
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (level_o <= bdrb_pkg::CntW'(bdrb_pkg::Depth)))
    else $error("level above depth");

  // an accepted beat changes the level, checked when the previous beat ran back to back
  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o && ($past(level_o, 3) == level_o)) |-> 1'b0 ||
    ($past(done_o, 3) == 1'b0))
    else $error("accepted beat left the level unchanged");

endmodule

bind byte_deque_ring_buffer_top bdrb_checker u_bdrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .accepted_o (accepted_o),
  .data_out_o (data_out_o),
  .level_o    (level_o)
);

`default_nettype wire

[sim/tb_top.sv]
module tb_top;

  // one result beat as the block reports it
  typedef struct packed {
    logic                      accepted;
    logic [7:0]                data;
    logic [bdrb_pkg::CntW-1:0] level;
  } deque_result_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_CAP
  } row_kind_e;

  // directed step: a command beat or a capacity write
  typedef struct packed {
    row_kind_e                 kind;
    bdrb_pkg::cmd_e            op;
    logic [bdrb_pkg::CntW-1:0] arg;
    logic                      typed;
    deque_result_t             want;
  } plan_row_t;

  // random phase: capacity written first, then a run of beats
  typedef struct packed {
    logic [bdrb_pkg::CntW-1:0] cap;
    logic [11:0]               beats;
    logic [6:0]                push_pct;
  } phase_t;

  localparam int NumRows     = 25;
  localparam int NumPhases   = 9;
  localparam int BurstPhase  = 0;
  localparam int CycleLimit  = 400000;
  localparam int MaxReported = 10;

  // directed part: empty, extremes of data, both ends, wrap at tiny capacities
  localparam plan_row_t PLAN [NumRows] = '{
    '{ROW_BEAT, bdrb_pkg::CMD_POP_HEAD,  11'h000, 1'b1, '{1'b0, 8'h00, 11'd0}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h0ff, 1'b1, '{1'b0, 8'h00, 11'd0}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_TAIL, 11'h0ff, 1'b1, '{1'b1, 8'h00, 11'd1}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h000, 1'b1, '{1'b1, 8'h00, 11'd2}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_TAIL, 11'h055, 1'b1, '{1'b1, 8'h00, 11'd3}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h0aa, 1'b1, '{1'b1, 8'h00, 11'd4}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_HEAD,  11'h000, 1'b1, '{1'b1, 8'haa, 11'd3}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h0ff, 1'b1, '{1'b1, 8'h55, 11'd2}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_HEAD,  11'h000, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h000, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h000, 1'b1, '{1'b0, 8'h00, 11'd0}},
    '{ROW_CAP,  bdrb_pkg::CMD_PUSH_TAIL, 11'd0,   1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h080, 1'b1, '{1'b1, 8'h00, 11'd1}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_TAIL, 11'h001, 1'b1, '{1'b0, 8'h00, 11'd1}},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h07f, 1'b1, '{1'b0, 8'h00, 11'd1}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h000, 1'b1, '{1'b1, 8'h80, 11'd0}},
    '{ROW_CAP,  bdrb_pkg::CMD_PUSH_TAIL, 11'd2,   1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h012, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_TAIL, 11'h034, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_HEAD, 11'h056, 1'b1, '{1'b0, 8'h00, 11'd2}},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_TAIL,  11'h000, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_HEAD,  11'h000, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_POP_HEAD,  11'h000, 1'b1, '{1'b0, 8'h00, 11'd0}},
    '{ROW_CAP,  bdrb_pkg::CMD_PUSH_TAIL, 11'd2047, 1'b0, '0},
    '{ROW_BEAT, bdrb_pkg::CMD_PUSH_TAIL, 11'h0c3, 1'b1, '{1'b1, 8'h00, 11'd1}}
  };

  // first phase runs at the full depth, later ones mostly use small capacities, the last two again the full depth
  localparam phase_t PHASES [NumPhases] = '{
    '{11'd1500, 12'd120,  7'd98},
    '{11'd0,    12'd40,   7'd50},
    '{11'd1,    12'd30,   7'd45},
    '{11'd2,    12'd40,   7'd50},
    '{11'd3,    12'd60,   7'd55},
    '{11'd7,    12'd60,   7'd50},
    '{11'd16,   12'd80,   7'd60},
    '{11'd2047, 12'd60,   7'd50},
    '{11'd1024, 12'd40,   7'd50}
  };

  logic                      clk_i      = 1'b0;
  logic                      rst_ni     = 1'b0;
  logic                      start      = 1'b0;
  logic [1:0]                cmd_i      = '0;
  logic [7:0]                data_in_i  = '0;
  logic                      cfg_we_i   = 1'b0;
  logic [bdrb_pkg::CntW-1:0] cfg_data_i = '0;
  logic                      busy;
  logic                      done_o;
  logic                      accepted_o;
  logic [7:0]                data_out_o;
  logic [bdrb_pkg::CntW-1:0] level_o;

  // predictor state
  logic [7:0] ring_bytes [bdrb_pkg::Depth];
  int         head_slot    = 0;
  int         tail_slot    = 0;
  int         held_bytes   = 0;
  int         slots_in_use = int'(bdrb_pkg::Depth);

  deque_result_t pending_results [$];
  int            fail_count  = 0;
  int            cycle_count = 0;
  bit            idle_on     = 1'b1;

  byte_deque_ring_buffer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .data_in_i  (data_in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .accepted_o (accepted_o),
    .data_out_o (data_out_o),
    .level_o    (level_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // one deque operation on the predictor state
  function automatic deque_result_t apply_deque_op(bdrb_pkg::cmd_e op, logic [7:0] din);
    deque_result_t r;
    r = '0;
    case (op)
      bdrb_pkg::CMD_PUSH_TAIL: begin
        if (held_bytes < slots_in_use) begin
          ring_bytes[tail_slot] = din;
          tail_slot = (tail_slot + 1 >= slots_in_use) ? 0 : tail_slot + 1;
          held_bytes++;
          r.accepted = 1'b1;
        end
      end
      bdrb_pkg::CMD_PUSH_HEAD: begin
        if (held_bytes < slots_in_use) begin
          head_slot = (head_slot == 0 || head_slot >= slots_in_use) ?
                      slots_in_use - 1 : head_slot - 1;
          ring_bytes[head_slot] = din;
          held_bytes++;
          r.accepted = 1'b1;
        end
      end
      bdrb_pkg::CMD_POP_HEAD: begin
        if (held_bytes != 0) begin
          r.data = ring_bytes[head_slot];
          head_slot = (head_slot + 1 >= slots_in_use) ? 0 : head_slot + 1;
          held_bytes--;
          r.accepted = 1'b1;
        end
      end
      bdrb_pkg::CMD_POP_TAIL: begin
        if (held_bytes != 0) begin
          tail_slot = (tail_slot == 0 || tail_slot >= slots_in_use) ?
                      slots_in_use - 1 : tail_slot - 1;
          r.data = ring_bytes[tail_slot];
          held_bytes--;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.level = bdrb_pkg::CntW'(held_bytes);
    return r;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MaxReported) $display("[%0t] %s", $time, what);
  endfunction

  // present one command beat, idling at random first, and wait until busy is low
  task automatic issue_op(bdrb_pkg::cmd_e op, logic [7:0] din,
                          output deque_result_t predicted);
    while (idle_on && $urandom_range(99) < 37) begin
      start     <= 1'b0;
      cmd_i     <= 2'($urandom);
      data_in_i <= 8'($urandom);
      @(posedge clk_i);
    end
    start     <= 1'b1;
    cmd_i     <= op;
    data_in_i <= din;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_deque_op(op, din);
  endtask

  // capacity write once the block has drained
  task automatic set_capacity(logic [bdrb_pkg::CntW-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    slots_in_use = (value == 0) ? 1 :
                   (value > bdrb_pkg::Depth) ? int'(bdrb_pkg::Depth) : int'(value);
    head_slot    = 0;
    tail_slot    = 0;
    held_bytes   = 0;
  endtask

  // result beats against the oldest expectation
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_failure("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (accepted_o !== want.accepted || data_out_o !== want.data ||
            level_o !== want.level) begin
          note_failure($sformatf(
              "mismatch: exp acc %0b data %02h level %0d, got acc %0b data %02h level %0d",
              want.accepted, want.data, want.level,
              accepted_o, data_out_o, level_o));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    deque_result_t  predicted;
    bdrb_pkg::cmd_e op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumRows; i++) begin
      if (PLAN[i].kind == ROW_CAP) begin
        set_capacity(PLAN[i].arg);
      end else begin
        issue_op(PLAN[i].op, PLAN[i].arg[7:0], predicted);
        pending_results.push_back(PLAN[i].typed ? PLAN[i].want : predicted);
      end
    end

    // random phases, the start of the first, full-depth phase runs back to back
    for (int p = 0; p < NumPhases; p++) begin
      set_capacity(PHASES[p].cap);
      for (int n = 0; n < int'(PHASES[p].beats); n++) begin
        idle_on = !(p == BurstPhase && n < 100);
        if ($urandom_range(99) < PHASES[p].push_pct) begin
          op = $urandom_range(1) ? bdrb_pkg::CMD_PUSH_HEAD : bdrb_pkg::CMD_PUSH_TAIL;
        end else begin
          op = $urandom_range(1) ? bdrb_pkg::CMD_POP_TAIL : bdrb_pkg::CMD_POP_HEAD;
        end
        issue_op(op, 8'($urandom), predicted);
        pending_results.push_back(predicted);
      end
    end

    // drain and settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
